[sv/gvs_pkg.sv]
// Shared types and constants of the Gaussian vector smoother.
package gvs_pkg;

  localparam int SAMPLE_W  = 8;
  localparam int WEIGHT_W  = 17;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_CENTER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_NEAR   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_FAR    = 2'd2;

  localparam logic [WEIGHT_W-1:0] WEIGHT_CENTER_RST = 17'd65536;
  localparam logic [WEIGHT_W-1:0] WEIGHT_NEAR_RST   = 17'd2879;
  localparam logic [WEIGHT_W-1:0] WEIGHT_FAR_RST    = 17'd0;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                last;
  } in_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] smoothed;
    logic                end_of_sequence;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_NORM,
    ST_DIV,
    ST_OUT
  } state_t;

endpackage

[sv/gvs_divider.sv]
// Restoring shift-subtract divider that produces one quotient bit per cycle.
module gvs_divider import gvs_pkg::*; #(
  parameter int NUM_W = 30,
  parameter int DEN_W = 21,
  parameter int QUO_W = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] dividend,
  input  logic [DEN_W-1:0] divisor,
  output logic             done,
  output logic [QUO_W-1:0] quotient
);

  localparam int SH_W  = DEN_W + QUO_W - 1;
  localparam int CMP_W = (NUM_W > SH_W) ? NUM_W : SH_W;
  localparam int CNT_W = (QUO_W > 1) ? $clog2(QUO_W) : 1;

  logic [NUM_W-1:0] rem;
  logic [SH_W-1:0]  dsh;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [CMP_W-1:0] rem_x;
  logic [CMP_W-1:0] dsh_x;
  logic [CMP_W-1:0] rem_sub;
  logic             fits;

  // The caller guarantees the quotient fits in QUO_W bits.
  assign rem_x   = CMP_W'(rem);
  assign dsh_x   = CMP_W'(dsh);
  assign fits    = rem_x >= dsh_x;
  assign rem_sub = rem_x - dsh_x;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(QUO_W - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= dividend;
      dsh      <= {divisor, {(QUO_W-1){1'b0}}};
      quotient <= '0;
    end else if (busy) begin
      if (fits) begin
        rem <= rem_sub[NUM_W-1:0];
      end
      quotient <= {quotient[QUO_W-2:0], fits};
      dsh      <= dsh >> 1;
    end
  end

endmodule

[sv/gaussian_vector_smoother_top.sv]
// Top level of the Gaussian vector smoother with edge-normalized weights.
//
// This block smooths a sequence of 8-bit values with a symmetric kernel of
// KERNEL_RADIUS taps on each side, whose weights at distance 0, 1 and 2 are the
// unsigned Q16 registers weight_center, weight_near and weight_far (larger
// distances weigh zero). Each output is the weighted sum of the neighbors that
// lie inside the sequence divided by the sum of those same weights, rounded to
// nearest with halves rounded up; if all those weights are zero the output is
// the sample itself. Outputs trail the input by KERNEL_RADIUS samples, and the
// input transaction marked last releases all remaining outputs of the sequence,
// the final one flagged end_of_sequence, and starts a new sequence. The block
// works on one input transaction at a time and holds in_stall high until every
// result it causes has been taken. Each result passes through the shared
// multiply-accumulate unit, a normalize step, the bit-serial divider (one
// quotient bit per cycle, skipped when the weights sum to zero) and the
// output. An input that causes no result is taken without leaving the idle
// state. Weight registers should be written only while the block is idle.
module gaussian_vector_smoother_top import gvs_pkg::*; #(
  parameter int KERNEL_RADIUS = 2
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_t                  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_t                 out_data,
  input  logic                 cfg_write_enable,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WEIGHT_W-1:0]  cfg_data
);

  localparam int SPAN   = 2 * KERNEL_RADIUS;
  localparam int CW     = $clog2(SPAN + 1);
  localparam int KW     = CW + 2;
  localparam int PROD_W = WEIGHT_W + SAMPLE_W;
  localparam int DEN_W  = WEIGHT_W + $clog2(SPAN + 1);
  localparam int ACC_W  = PROD_W + $clog2(SPAN + 1) + 1;

  // Weight registers.
  logic [WEIGHT_W-1:0] weight_center;
  logic [WEIGHT_W-1:0] weight_near;
  logic [WEIGHT_W-1:0] weight_far;

  // Sequence history: the SPAN samples before the current one, newest first,
  // and how many of them belong to the current sequence.
  logic [SAMPLE_W-1:0] recent [SPAN];
  logic [CW-1:0]       seen;

  // Working copy of the window for the transaction under way; entry SPAN holds
  // the newest sample.
  logic [SAMPLE_W-1:0] win [SPAN+1];
  logic                last_q;
  logic [CW-1:0]       lo_q;
  logic [CW-1:0]       pos;
  logic [CW-1:0]       tap;
  logic [ACC_W-1:0]    num;
  logic [DEN_W-1:0]    den;
  logic [SAMPLE_W-1:0] center;
  logic [SAMPLE_W-1:0] result;

  state_t state;
  state_t state_next;

  logic in_accept;
  logic has_out;
  logic [CW-1:0] lo_in;
  logic [CW-1:0] pos_start;
  logic [CW-1:0] hi;
  logic pos_is_hi;

  logic signed [KW-1:0] k_s;
  logic                 k_in;
  logic [CW-1:0]        tap_dist;
  logic [WEIGHT_W-1:0]  w_sel;
  logic [WEIGHT_W-1:0]  w_k;
  logic [SAMPLE_W-1:0]  sample_k;
  logic [PROD_W-1:0]    prod;

  logic               div_start;
  logic               div_done;
  logic [SAMPLE_W-1:0] div_quotient;
  logic [ACC_W-1:0]   dividend;

  assign in_accept = in_valid && !in_stall;

  // The first output position of a transaction is the later of the kernel
  // radius and the oldest sample of the sequence still in the window. A last
  // sample always produces at least one output.
  assign lo_in     = CW'(SPAN) - seen;
  assign pos_start = (lo_in > CW'(KERNEL_RADIUS)) ? lo_in : CW'(KERNEL_RADIUS);
  assign has_out   = in_data.last || (seen >= CW'(KERNEL_RADIUS));
  assign hi        = last_q ? CW'(SPAN) : CW'(KERNEL_RADIUS);
  assign pos_is_hi = pos == hi;

  // Shared multiply-accumulate unit: one kernel tap per cycle.
  assign k_s = $signed({2'b00, pos}) + $signed({2'b00, tap}) - $signed(KW'(KERNEL_RADIUS));
  assign k_in = (k_s >= $signed({2'b00, lo_q})) && (k_s <= $signed(KW'(SPAN)));
  assign tap_dist = (tap >= CW'(KERNEL_RADIUS)) ? (tap - CW'(KERNEL_RADIUS))
                                                : (CW'(KERNEL_RADIUS) - tap);

  always_comb begin
    if (tap_dist == CW'(0)) begin
      w_sel = weight_center;
    end else if (tap_dist == CW'(1)) begin
      w_sel = weight_near;
    end else if (tap_dist == CW'(2)) begin
      w_sel = weight_far;
    end else begin
      w_sel = '0;
    end
  end

  assign sample_k = k_in ? win[k_s[CW-1:0]] : '0;
  assign w_k      = k_in ? w_sel : '0;
  assign prod     = PROD_W'(w_k) * PROD_W'(sample_k);

  // Rounding to nearest adds half the divisor before the division.
  assign dividend = num + ACC_W'(den >> 1);

  gvs_divider #(
    .NUM_W (ACC_W),
    .DEN_W (DEN_W),
    .QUO_W (SAMPLE_W)
  ) u_gvs_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (den),
    .done     (div_done),
    .quotient (div_quotient)
  );

  // Next-state logic of the sequencer.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_accept && has_out) begin
          state_next = ST_MAC;
        end
      end
      ST_MAC: begin
        if (tap == CW'(SPAN)) begin
          state_next = ST_NORM;
        end
      end
      ST_NORM: begin
        state_next = (den == '0) ? ST_OUT : ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_stall) begin
          state_next = pos_is_hi ? ST_IDLE : ST_MAC;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_stall  = 1'b1;
    out_valid = 1'b0;
    div_start = 1'b0;
    case (state)
      ST_IDLE: in_stall  = 1'b0;
      ST_NORM: div_start = den != '0;
      ST_OUT:  out_valid = 1'b1;
      default: ;
    endcase
  end

  assign out_data.smoothed        = result;
  assign out_data.end_of_sequence = last_q && (pos == CW'(SPAN));

  // Control state, weights and sequence history.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      seen          <= '0;
      weight_center <= WEIGHT_CENTER_RST;
      weight_near   <= WEIGHT_NEAR_RST;
      weight_far    <= WEIGHT_FAR_RST;
      for (int i = 0; i < SPAN; i++) begin
        recent[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (cfg_write_enable) begin
        case (cfg_index)
          CFG_WEIGHT_CENTER: weight_center <= cfg_data;
          CFG_WEIGHT_NEAR:   weight_near   <= cfg_data;
          CFG_WEIGHT_FAR:    weight_far    <= cfg_data;
          default: ;
        endcase
      end
      if (in_accept) begin
        if (in_data.last) begin
          seen <= '0;
          for (int i = 0; i < SPAN; i++) begin
            recent[i] <= '0;
          end
        end else begin
          seen      <= (seen == CW'(SPAN)) ? seen : seen + 1'b1;
          recent[0] <= in_data.sample;
          for (int i = 1; i < SPAN; i++) begin
            recent[i] <= recent[i-1];
          end
        end
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_accept) begin
          win[SPAN] <= in_data.sample;
          for (int j = 0; j < SPAN; j++) begin
            win[j] <= recent[SPAN-1-j];
          end
          last_q <= in_data.last;
          lo_q   <= lo_in;
          pos    <= pos_start;
          tap    <= '0;
          num    <= '0;
          den    <= '0;
        end
      end
      ST_MAC: begin
        num <= num + ACC_W'(prod);
        den <= den + DEN_W'(w_k);
        tap <= tap + 1'b1;
        if (tap == CW'(KERNEL_RADIUS)) begin
          center <= sample_k;
        end
      end
      ST_NORM: begin
        if (den == '0) begin
          result <= center;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          result <= div_quotient;
        end
      end
      ST_OUT: begin
        if (!out_stall && !pos_is_hi) begin
          pos <= pos + 1'b1;
          tap <= '0;
          num <= '0;
          den <= '0;
        end
      end
      default: ;
    endcase
  end

endmodule

[sv/gvs_checker.sv]
// Port-level assertions for the Gaussian vector smoother and their bind.
module gvs_checker import gvs_pkg::*; (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input in_t  in_data,
  input logic out_valid,
  input logic out_stall,
  input out_t out_data
);

  // A result waiting on a stalled output stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or vanished");

  // No new transaction is taken while a result is pending.
  a_busy_while_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input taken while a result is pending");

  // A last sample always produces output, so the block goes busy.
  a_last_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && in_data.last |=> in_stall)
    else $error("last sample produced no work");

  // After the final result of a sequence the block returns to idle.
  a_eos_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && out_data.end_of_sequence |=> !out_valid && !in_stall)
    else $error("block not idle after end of sequence");

endmodule

bind gaussian_vector_smoother_top gvs_checker u_gvs_checker (.*);
